FILE: rtl/flash_page_rmw_eeprom_core_defines.svh
// ----------------------------------------------------------------------------
// flash_page_rmw_eeprom_core_defines.svh
// Assertion macros shared by the flash EEPROM emulation RTL.
// ----------------------------------------------------------------------------
`ifndef FLASH_PAGE_RMW_EEPROM_CORE_DEFINES_SVH
`define FLASH_PAGE_RMW_EEPROM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define FPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Condition must never be seen outside reset.
`define FPR_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define FPR_ASSERT(label, clk, rst_n, prop, msg)
`define FPR_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared constants and types of the flash EEPROM emulation block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

    // PAGE_WORDS must be a power of two.
    localparam int PAGE_WORDS_DEF = 512;
    localparam int PAGE_COUNT_DEF = 16;

    localparam int BASE_W   = 13;
    localparam int OFFSET_W = 13;
    localparam int DATA_W   = 16;
    localparam int COUNT_W  = 2;
    localparam int SUM_W    = 14;

    localparam logic [DATA_W-1:0]  ERASED_WORD = 16'hFFFF;
    localparam logic [7:0]         PAD_BYTE    = 8'hFF;

    localparam logic               OP_READ  = 1'b0;
    localparam logic               OP_WRITE = 1'b1;

    localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              page_erased;
        logic              address_error;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/fpr_flash_mem.sv
// ----------------------------------------------------------------------------
// fpr_flash_mem
// Flash word array: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_flash_mem
    import fpr_pkg::*;
#(
    parameter int DEPTH = PAGE_WORDS_DEF * PAGE_COUNT_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/fpr_page_buf.sv
// ----------------------------------------------------------------------------
// fpr_page_buf
// Page buffer: holds one page while it is merged and programmed back.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_page_buf
    import fpr_pkg::*;
#(
    parameter int DEPTH = PAGE_WORDS_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/fpr_ctrl.sv
// ----------------------------------------------------------------------------
// fpr_ctrl
// Sequencer: clear sweep, word lookup, direct program or page copy/program.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flash_page_rmw_eeprom_core_defines.svh"

module fpr_ctrl
    import fpr_pkg::*;
#(
    parameter int PAGE_WORDS  = PAGE_WORDS_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    localparam int FLASH_WORDS = PAGE_WORDS * PAGE_COUNT,
    localparam int IDX_W       = $clog2(PAGE_WORDS),
    localparam int AW          = $clog2(FLASH_WORDS)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // item channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                opcode,
    input  wire logic [OFFSET_W-1:0] word_offset,
    input  wire logic [DATA_W-1:0]   write_data,
    input  wire logic [COUNT_W-1:0]  byte_count,
    input  wire logic [BASE_W-1:0]   base_word,
    // result hand-off
    output logic                     res_valid,
    input  wire logic                res_ready,
    output result_t                  res,
    // flash array
    output logic                     flash_rd_en,
    output logic      [AW-1:0]       flash_raddr,
    input  wire logic [DATA_W-1:0]   flash_rdata,
    output logic                     flash_we,
    output logic      [AW-1:0]       flash_waddr,
    output logic      [DATA_W-1:0]   flash_wdata,
    // page buffer
    output logic                     buf_rd_en,
    output logic      [IDX_W-1:0]    buf_raddr,
    input  wire logic [DATA_W-1:0]   buf_rdata,
    output logic                     buf_we,
    output logic      [IDX_W-1:0]    buf_waddr,
    output logic      [DATA_W-1:0]   buf_wdata
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_LOOK  = 6'b000100,
        ST_COPY  = 6'b001000,
        ST_PROG  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    localparam logic [AW-1:0] CLR_LAST  = AW'(FLASH_WORDS - 1);
    localparam logic [AW-1:0] PAGE_MASK = AW'(PAGE_WORDS - 1);

    state_t            state_reg, state_next;
    logic [IDX_W:0]    cnt_reg, cnt_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              write_reg, write_next;
    logic              nop_reg, nop_next;
    result_t           res_reg, res_next;

    logic [SUM_W-1:0]  sum;
    logic              addr_err;
    logic              accept;
    logic [IDX_W:0]    cnt_prev;
    logic [AW-1:0]     page_base;
    logic [IDX_W-1:0]  slot;

    assign sum       = SUM_W'(base_word) + SUM_W'(word_offset);
    assign addr_err  = 32'(sum) >= 32'(FLASH_WORDS);
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cnt_prev  = cnt_reg - (IDX_W + 1)'(1);
    assign page_base = addr_reg & ~PAGE_MASK;
    assign slot      = addr_reg[IDX_W-1:0];
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        addr_next   = addr_reg;
        value_next  = value_reg;
        write_next  = write_reg;
        nop_next    = nop_reg;
        res_next    = res_reg;

        flash_rd_en = 1'b0;
        flash_raddr = AW'(sum);
        flash_we    = 1'b0;
        flash_waddr = addr_reg;
        flash_wdata = value_reg;
        buf_rd_en   = 1'b0;
        buf_raddr   = cnt_reg[IDX_W-1:0];
        buf_we      = 1'b0;
        buf_waddr   = cnt_prev[IDX_W-1:0];
        buf_wdata   = (cnt_prev[IDX_W-1:0] == slot) ? value_reg : flash_rdata;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep the whole array to the erased value
                flash_we    = 1'b1;
                flash_waddr = clr_reg;
                flash_wdata = ERASED_WORD;
                clr_next    = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = AW'(sum);
                    write_next = (opcode == OP_WRITE);
                    nop_next   = (byte_count == CNT_NONE);
                    value_next = (byte_count == CNT_ONE) ?
                                 {write_data[DATA_W-1:8], PAD_BYTE} : write_data;
                    if (addr_err)
                    begin
                        res_next   = '{read_data: '0, page_erased: 1'b0,
                                       address_error: 1'b1};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        flash_rd_en = 1'b1;
                        state_next  = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                res_next   = '{read_data: '0, page_erased: 1'b0, address_error: 1'b0};
                state_next = ST_DONE;
                if (!write_reg)
                begin
                    res_next.read_data = flash_rdata;
                end
                else if (!nop_reg)
                begin
                    if (flash_rdata == ERASED_WORD)
                    begin
                        flash_we = 1'b1;
                    end
                    else
                    begin
                        res_next.page_erased = 1'b1;
                        cnt_next             = '0;
                        state_next           = ST_COPY;
                    end
                end
            end
            ST_COPY:
            begin
                // read word i, store word i-1 with the new word merged at its slot
                flash_rd_en = !cnt_reg[IDX_W];
                flash_raddr = page_base | AW'(cnt_reg[IDX_W-1:0]);
                buf_we      = (cnt_reg != '0);
                cnt_next    = cnt_reg + (IDX_W + 1)'(1);
                if (cnt_reg[IDX_W])
                begin
                    cnt_next   = '0;
                    state_next = ST_PROG;
                end
            end
            ST_PROG:
            begin
                // page programmed back word by word from the buffer
                buf_rd_en   = !cnt_reg[IDX_W];
                flash_we    = (cnt_reg != '0);
                flash_waddr = page_base | AW'(cnt_prev[IDX_W-1:0]);
                flash_wdata = buf_rdata;
                cnt_next    = cnt_reg + (IDX_W + 1)'(1);
                if (cnt_reg[IDX_W])
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        value_reg <= value_next;
        write_reg <= write_next;
        nop_reg   <= nop_next;
        res_reg   <= res_next;
    end

    `FPR_NEVER(a_no_same_word_rw, clk, rst_n,
               flash_rd_en && flash_we && (flash_raddr == flash_waddr),
               "flash read and write hit the same word")
    `FPR_ASSERT(a_accept_moves_on, clk, rst_n,
                accept |=> (state_reg == ST_LOOK || state_reg == ST_DONE),
                "accepted beat did not start a lookup")
    `FPR_ASSERT(a_cnt_bounded, clk, rst_n,
                cnt_reg <= (IDX_W + 1)'(PAGE_WORDS),
                "page counter ran past the page")
    `FPR_ASSERT(a_copy_then_prog, clk, rst_n,
                (state_reg == ST_COPY && cnt_reg[IDX_W]) |=>
                    (state_reg == ST_PROG && cnt_reg == '0),
                "copy pass did not hand over to program")

endmodule

`default_nettype wire

FILE: rtl/flash_page_rmw_eeprom_core.sv
// ----------------------------------------------------------------------------
// flash_page_rmw_eeprom_core
// EEPROM emulation on paged flash: word reads, word writes with page rewrite.
// In channel: in_valid/in_stall carry opcode, word_offset, write_data and
// byte_count. Out channel: out_valid/out_stall carry read_data, page_erased
// and address_error, one beat per input beat, in order.
// cfg_we/cfg_wdata set the region base word; write it only while idle.
// Sequence: an address error goes straight to the result, a read or direct
// program looks up the word first; a page rewrite has two passes: one copies
// the page into the buffer through the flash read port, one pass programs it
// back through the flash write port. One item is worked at a time.
// Reset: the array is swept to erased, word by word through the flash write
// port; in_stall stays high meanwhile, config writes are still taken.
// A stalled result beat holds in the output register; the next item may be
// accepted behind it, but its result waits until that beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_page_rmw_eeprom_core
    import fpr_pkg::*;
#(
    parameter int PAGE_WORDS = PAGE_WORDS_DEF,
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // config
    input  wire logic                cfg_we,
    input  wire logic [BASE_W-1:0]   cfg_wdata,
    // input beats
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                opcode,
    input  wire logic [OFFSET_W-1:0] word_offset,
    input  wire logic [DATA_W-1:0]   write_data,
    input  wire logic [COUNT_W-1:0]  byte_count,
    // result beats
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [DATA_W-1:0]   read_data,
    output logic                     page_erased,
    output logic                     address_error
);

    localparam int FLASH_WORDS = PAGE_WORDS * PAGE_COUNT;
    localparam int IDX_W       = $clog2(PAGE_WORDS);
    localparam int AW          = $clog2(FLASH_WORDS);

    // region base register
    logic [BASE_W-1:0] base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_wdata;
        end
    end

    // sequencer to memories
    logic              flash_rd_en, flash_we;
    logic [AW-1:0]     flash_raddr, flash_waddr;
    logic [DATA_W-1:0] flash_rdata, flash_wdata;
    logic              buf_rd_en, buf_we;
    logic [IDX_W-1:0]  buf_raddr, buf_waddr;
    logic [DATA_W-1:0] buf_rdata, buf_wdata;

    logic    res_valid;
    logic    res_ready;
    result_t res;

    fpr_ctrl #(
        .PAGE_WORDS (PAGE_WORDS),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .word_offset (word_offset),
        .write_data  (write_data),
        .byte_count  (byte_count),
        .base_word   (base_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .flash_rd_en (flash_rd_en),
        .flash_raddr (flash_raddr),
        .flash_rdata (flash_rdata),
        .flash_we    (flash_we),
        .flash_waddr (flash_waddr),
        .flash_wdata (flash_wdata),
        .buf_rd_en   (buf_rd_en),
        .buf_raddr   (buf_raddr),
        .buf_rdata   (buf_rdata),
        .buf_we      (buf_we),
        .buf_waddr   (buf_waddr),
        .buf_wdata   (buf_wdata)
    );

    fpr_flash_mem #(
        .DEPTH (FLASH_WORDS)
    ) u_flash (
        .clk   (clk),
        .rd_en (flash_rd_en),
        .raddr (flash_raddr),
        .rdata (flash_rdata),
        .we    (flash_we),
        .waddr (flash_waddr),
        .wdata (flash_wdata)
    );

    fpr_page_buf #(
        .DEPTH (PAGE_WORDS)
    ) u_buf (
        .clk   (clk),
        .rd_en (buf_rd_en),
        .raddr (buf_raddr),
        .rdata (buf_rdata),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata)
    );

    // output register: load when empty or when the held beat leaves
    logic    out_valid_reg;
    result_t out_reg;

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            // drop the beat once taken
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = out_reg.read_data;
    assign page_erased   = out_reg.page_erased;
    assign address_error = out_reg.address_error;

endmodule

`default_nettype wire
